// File: rtl/round_robin_time_slice_scheduler_assert.svh
// Assertion shorthands for the checker file rtl/rrts_chk.sv.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// File: rtl/rrts_pkg.sv
package rrts_pkg;

	localparam int BURST_W   = 16;
	localparam int SLOT_O_W  = 4;
	localparam int ELAPSED_W = 32;
	localparam int SLICE_W   = 8;
	localparam int GROUP_W   = 16;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 3;
	localparam int M_PAD_W   = M_TDATA_W - SLOT_O_W - BURST_W - ELAPSED_W;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [SLICE_W-1:0]   QUANTUM_RESET = 8'd2;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic accept;
		logic commit;
	} rrts_cmd_t;

endpackage

// File: rtl/round_robin_time_slice_scheduler.sv
// The accepting edge launches the task-memory read; the result word enters the output register
//   at the commit in EXEC, which waits while the previous result still sits there.
// One word at a time: the next word is taken only after the previous one commits, due to the
//   registered read of the task memories (read at accept, write-back and relink at commit).
// The input side accepts the next word while a result still waits on the output side.
// Reset (arst_n low, asynchronous): ring empty, counters and elapsed time zero,
//   quantum 2; task memories are not cleared and need no clearing pass.
module round_robin_time_slice_scheduler #(
	parameter int TASKS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// quantum register write port
	input  logic                               quantum_we,
	input  logic [rrts_pkg::SLICE_W-1:0]       quantum_wdata,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rrts_pkg::S_TDATA_W-1:0]     s_tdata,  // [15:0] burst
	input  logic [rrts_pkg::S_TUSER_W-1:0]     s_tuser,  // [0] cmd (0 load, 1 tick)
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rrts_pkg::M_TDATA_W-1:0]     m_tdata,  // [3:0] task_slot, [19:4] remaining,
	                                                     // [51:20] elapsed, [55:52] zero
	output logic [rrts_pkg::M_TUSER_W-1:0]     m_tuser   // [0] finished, [1] idle, [2] rejected
);

	import rrts_pkg::*;

	rrts_cmd_t cmd;

	// Controller: two states. IDLE takes a word and launches the memory read
	// of the current task; EXEC evaluates the word, writes back, and loads the
	// result register, holding while the previous result is still unread.
	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Datapath: ring pointers, slot occupancy with a registered lowest-free
	// search, remaining-time and next-link memories, counters and the
	// result register. A load writes its new entry at accept and patches the
	// tail link at commit; a tick counts down, relinks a finished task, and
	// rotates the slice when the quantum runs out.
	rrts_dp #(.TASKS(TASKS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.quantum_we    (quantum_we),
		.quantum_wdata (quantum_wdata),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule

// File: rtl/rrts_ram.sv
module rrts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rrts_ctrl.sv
module rrts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output rrts_pkg::rrts_cmd_t cmd
);

	import rrts_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = out_valid_q;
	assign cmd.accept = s_tvalid && (state_q == S_IDLE);
	// finish only when the result register is free or being emptied
	assign cmd.commit = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/rrts_dp.sv
module rrts_dp #(
	parameter int TASKS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rrts_pkg::rrts_cmd_t                cmd,
	input  logic                               quantum_we,
	input  logic [rrts_pkg::SLICE_W-1:0]       quantum_wdata,
	input  logic [rrts_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [rrts_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic [rrts_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [rrts_pkg::M_TUSER_W-1:0]     m_tuser
);

	import rrts_pkg::*;

	localparam int SW  = $clog2(TASKS);
	localparam int CW  = $clog2(TASKS + 1);
	localparam int GW  = (TASKS < GROUP_W) ? TASKS : GROUP_W;
	localparam int NG  = (TASKS + GW - 1) / GW;
	localparam int GIW = $clog2(GW);

	localparam logic [CW-1:0] COUNT_FULL = CW'(TASKS);

	// control state
	logic [TASKS-1:0]     used_q, used_d;
	logic [SW-1:0]        head_q, head_d;
	logic [SW-1:0]        tail_q, tail_d;
	logic [SW-1:0]        cur_q, cur_d;
	logic [SW-1:0]        prv_q, prv_d;
	logic [SLICE_W-1:0]   slice_q, slice_d;
	logic [CW-1:0]        count_q, count_d;
	logic [ELAPSED_W-1:0] total_q, total_d;
	logic [SLICE_W-1:0]   quantum_q;

	// lowest-free-slot search, first level registered per group
	logic [NG*GW-1:0]     free_pad;
	logic [NG-1:0]        grp_any_d, grp_any_q;
	logic [GIW-1:0]       grp_idx_d [NG];
	logic [GIW-1:0]       grp_idx_q [NG];
	logic [SW-1:0]        free_slot;

	// item captured at accept
	logic                 cmd_q;
	logic [BURST_W-1:0]   burst_q;
	logic [SW-1:0]        ld_slot_q;

	// memories
	logic                 rem_we;
	logic [SW-1:0]        rem_waddr;
	logic [BURST_W-1:0]   rem_wdata;
	logic [BURST_W-1:0]   rem_rd;
	logic                 link_we;
	logic [SW-1:0]        link_waddr;
	logic [SW-1:0]        link_wdata;
	logic [SW-1:0]        link_rd;

	// item evaluation
	logic                 load_ok_in;
	logic                 load_ok;
	logic                 is_tick;
	logic [BURST_W-1:0]   rem_new;
	logic                 fin;
	logic [CW-1:0]        count_dec;
	logic [SLICE_W-1:0]   slice_inc;
	logic [SLICE_W-1:0]   q_eff;
	logic [SW-1:0]        out_slot;
	logic [BURST_W-1:0]   out_rem;
	logic                 out_fin;
	logic                 out_idle;
	logic                 out_rej;
	logic [M_TDATA_W-1:0] tdata_q;
	logic [M_TUSER_W-1:0] tuser_q;

	rrts_ram #(.WIDTH(BURST_W), .DEPTH(TASKS)) u_rem (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.re    (cmd.accept),
		.raddr (cur_q),
		.rdata (rem_rd)
	);

	rrts_ram #(.WIDTH(SW), .DEPTH(TASKS)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.accept),
		.raddr (cur_q),
		.rdata (link_rd)
	);

	always_comb begin
		free_pad              = '0;
		free_pad[TASKS-1:0]   = ~used_d;
		for (int g = 0; g < NG; g++) begin
			grp_any_d[g] = 1'b0;
			grp_idx_d[g] = '0;
			for (int b = GW - 1; b >= 0; b--) begin
				if (free_pad[g*GW + b]) begin
					grp_any_d[g] = 1'b1;
					grp_idx_d[g] = GIW'(b);
				end
			end
		end
	end

	always_comb begin
		free_slot = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				free_slot = SW'(g * GW) + SW'(grp_idx_q[g]);
			end
		end
	end

	assign load_ok_in = (s_tuser[0] == CMD_LOAD) && (s_tdata != '0) && (count_q < COUNT_FULL);
	assign load_ok    = (cmd_q == CMD_LOAD) && (burst_q != '0) && (count_q < COUNT_FULL);
	assign is_tick    = (cmd_q == CMD_TICK) && (count_q != '0);
	assign rem_new    = (rem_rd == '0) ? '0 : rem_rd - BURST_W'(1);
	assign fin        = (rem_new == '0);
	assign count_dec  = count_q - CW'(1);
	assign slice_inc  = slice_q + SLICE_W'(1);
	assign q_eff      = (quantum_q == '0) ? SLICE_W'(1) : quantum_q;

	// memory writes: new entry at accept, link repair and countdown at commit
	always_comb begin
		rem_we     = 1'b0;
		rem_waddr  = cur_q;
		rem_wdata  = rem_new;
		link_we    = 1'b0;
		link_waddr = tail_q;
		link_wdata = ld_slot_q;
		if (cmd.accept) begin
			rem_we     = load_ok_in;
			rem_waddr  = free_slot;
			rem_wdata  = s_tdata;
			link_we    = load_ok_in;
			link_waddr = free_slot;
			link_wdata = (count_q == '0) ? free_slot : head_q;
		end else if (cmd.commit) begin
			if (is_tick) begin
				rem_we     = 1'b1;
				link_we    = fin && (count_dec != '0);
				link_waddr = prv_q;
				link_wdata = link_rd;
			end else begin
				link_we    = load_ok && (count_q != '0);
			end
		end
	end

	always_comb begin
		used_d   = used_q;
		head_d   = head_q;
		tail_d   = tail_q;
		cur_d    = cur_q;
		prv_d    = prv_q;
		slice_d  = slice_q;
		count_d  = count_q;
		total_d  = total_q;
		out_slot = '0;
		out_rem  = '0;
		out_fin  = 1'b0;
		out_idle = (count_q == '0);
		out_rej  = 1'b0;
		if (cmd.commit) begin
			if (cmd_q == CMD_LOAD) begin
				if (!load_ok) begin
					out_rej = 1'b1;
				end else begin
					used_d[ld_slot_q] = 1'b1;
					if (count_q == '0) begin
						head_d  = ld_slot_q;
						cur_d   = ld_slot_q;
						prv_d   = ld_slot_q;
						slice_d = '0;
					end else if (cur_q == head_q) begin
						prv_d = ld_slot_q;
					end
					tail_d   = ld_slot_q;
					count_d  = count_q + CW'(1);
					out_slot = ld_slot_q;
					out_rem  = burst_q;
					out_idle = 1'b0;
				end
			end else if (is_tick) begin
				if (total_q != ELAPSED_MAX) begin
					total_d = total_q + ELAPSED_W'(1);
				end
				out_slot = cur_q;
				out_idle = 1'b0;
				if (fin) begin
					used_d[cur_q] = 1'b0;
					count_d       = count_dec;
					slice_d       = '0;
					out_fin       = 1'b1;
					if (count_dec == '0) begin
						head_d   = '0;
						tail_d   = '0;
						cur_d    = '0;
						prv_d    = '0;
						out_idle = 1'b1;
					end else begin
						if (cur_q == head_q) begin
							head_d = link_rd;
						end
						if (cur_q == tail_q) begin
							tail_d = prv_q;
						end
						cur_d = link_rd;
					end
				end else begin
					out_rem = rem_new;
					if (slice_inc >= q_eff) begin
						prv_d   = cur_q;
						cur_d   = link_rd;
						slice_d = '0;
					end else begin
						slice_d = slice_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			cur_q     <= '0;
			prv_q     <= '0;
			slice_q   <= '0;
			count_q   <= '0;
			total_q   <= '0;
			quantum_q <= QUANTUM_RESET;
			grp_any_q <= '1;
			for (int g = 0; g < NG; g++) begin
				grp_idx_q[g] <= '0;
			end
		end else begin
			used_q    <= used_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			cur_q     <= cur_d;
			prv_q     <= prv_d;
			slice_q   <= slice_d;
			count_q   <= count_d;
			total_q   <= total_d;
			grp_any_q <= grp_any_d;
			for (int g = 0; g < NG; g++) begin
				grp_idx_q[g] <= grp_idx_d[g];
			end
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q     <= s_tuser[0];
			burst_q   <= s_tdata;
			ld_slot_q <= free_slot;
		end
		if (cmd.commit) begin
			tdata_q <= {M_PAD_W'(0), total_d, out_rem, SLOT_O_W'(out_slot)};
			tuser_q <= {out_rej, out_idle, out_fin};
		end
	end

	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

endmodule

// File: rtl/rrts_chk.sv
`include "round_robin_time_slice_scheduler_assert.svh"

module rrts_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rrts_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [rrts_pkg::M_TUSER_W-1:0] m_tuser
);

	import rrts_pkg::*;

	// a result word stays until taken
	`RRTS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// one word in flight: input side closes right after an accept
	`RRTS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a refused load never reports a finished task
	`RRTS_ASSERT_NOW(a_fin_rej_excl, clk, arst_n, m_tvalid, !(m_tuser[0] && m_tuser[2]))
	// a finished task has nothing left to run
	`RRTS_ASSERT_NOW(a_fin_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[19:4] == 16'd0)
	// empty ring without a finish reports slot and remaining as zero
	`RRTS_ASSERT_NOW(a_idle_zero, clk, arst_n, m_tvalid && m_tuser[1] && !m_tuser[0],
		m_tdata[19:0] == 20'd0)

endmodule

bind round_robin_time_slice_scheduler rrts_chk u_rrts_chk (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rrts_pkg::*;

	localparam int TASKS        = 16;
	localparam int SETTLE       = 4;     // idle cycles before a quantum write
	localparam int HOLDOFF_AT   = 400;   // words in before the long output stall
	localparam int HOLDOFF_LEN  = 300;
	localparam int CALM_LO      = 600;   // word window with no random idling
	localparam int CALM_HI      = 800;
	localparam int STALL_LIMIT  = 4000;  // cycles with no transfer at all
	localparam int PHASE_WORDS  = 195;

	typedef enum logic [1:0] {
		STIM_WORD,
		STIM_QUANTUM,
		STIM_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t        kind;
		logic              cmd;
		logic [BURST_W-1:0] burst;
		logic [SLICE_W-1:0] quantum;
	} stim_t;

	typedef struct packed {
		logic [SLOT_O_W-1:0]  slot;
		logic [BURST_W-1:0]   remaining;
		logic                 finished;
		logic                 idle;
		logic                 rejected;
		logic [ELAPSED_W-1:0] elapsed;
	} sched_report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 quantum_we = 1'b0;
	logic [SLICE_W-1:0]   quantum_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // [15:0] burst
	logic [S_TUSER_W-1:0] s_tuser = '0;   // [0] cmd
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [3:0] slot, [19:4] remaining, [51:20] elapsed
	logic [M_TUSER_W-1:0] m_tuser;        // [0] finished, [1] idle, [2] rejected

	round_robin_time_slice_scheduler #(.TASKS(TASKS)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.quantum_we    (quantum_we),
		.quantum_wdata (quantum_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stimulus still to be driven, and reports owed by the scheduler.
	stim_t         load_tick_q[$];
	sched_report_t slot_reports_q[$];

	int unsigned words_sent = 0;
	int unsigned words_in = 0;
	int unsigned reports_out = 0;
	int unsigned mismatches = 0;

	// Scheduler shadow state.
	logic [BURST_W-1:0]   task_left [TASKS];
	logic [3:0]           task_link [TASKS];
	logic                 task_busy [TASKS];
	logic [3:0]           ring_head, ring_tail, run_task, run_prev;
	logic [SLICE_W-1:0]   slice_cnt, quantum_reg;
	int                   live_tasks;
	logic [ELAPSED_W-1:0] elapsed_units;

	initial begin
		foreach (task_busy[i]) task_busy[i] = 1'b0;
		ring_head = '0;
		ring_tail = '0;
		run_task = '0;
		run_prev = '0;
		slice_cnt = '0;
		quantum_reg = QUANTUM_RESET;
		live_tasks = 0;
		elapsed_units = '0;
	end

	// Work out the report of one word and advance the shadow ring.
	function automatic sched_report_t schedule_word(logic cmd, logic [BURST_W-1:0] burst);
		sched_report_t rep;
		logic [3:0] slot, cur, prv, nxt;
		logic [BURST_W-1:0] rem;
		logic [SLICE_W-1:0] q;
		rep = '0;
		if (cmd == CMD_LOAD) begin
			if (burst == '0 || live_tasks >= TASKS) begin
				// refused: ring untouched
				rep.idle = (live_tasks == 0);
				rep.rejected = 1'b1;
			end else begin
				slot = '0;
				for (int i = TASKS - 1; i >= 0; i--)
					if (!task_busy[i]) slot = 4'(i);
				task_busy[slot] = 1'b1;
				task_left[slot] = burst;
				if (live_tasks == 0) begin
					task_link[slot] = slot;
					ring_head = slot;
					ring_tail = slot;
					run_task = slot;
					run_prev = slot;
					slice_cnt = '0;
				end else begin
					// append at the tail, close the ring back to the head
					task_link[ring_tail] = slot;
					task_link[slot] = ring_head;
					if (run_task == ring_head) run_prev = slot;
					ring_tail = slot;
				end
				live_tasks++;
				rep.slot = slot;
				rep.remaining = burst;
			end
		end else if (live_tasks == 0) begin
			rep.idle = 1'b1;
		end else begin
			cur = run_task;
			prv = run_prev;
			rem = task_left[cur];
			if (rem != '0) rem--;
			task_left[cur] = rem;
			if (elapsed_units != ELAPSED_MAX) elapsed_units++;
			rep.slot = cur;
			rep.remaining = rem;
			if (rem == '0) begin
				// unlink the finished task on this very tick
				task_busy[cur] = 1'b0;
				live_tasks--;
				if (live_tasks == 0) begin
					ring_head = '0;
					ring_tail = '0;
					run_task = '0;
					run_prev = '0;
				end else begin
					nxt = task_link[cur];
					task_link[prv] = nxt;
					if (cur == ring_head) ring_head = nxt;
					if (cur == ring_tail) ring_tail = prv;
					run_task = nxt;
				end
				slice_cnt = '0;
				rep.finished = 1'b1;
				rep.idle = (live_tasks == 0);
			end else begin
				q = (quantum_reg == '0) ? 8'd1 : quantum_reg;
				slice_cnt++;
				if (slice_cnt >= q) begin
					run_prev = cur;
					run_task = task_link[cur];
					slice_cnt = '0;
				end
			end
		end
		rep.elapsed = elapsed_units;
		return rep;
	endfunction

	function automatic void push_word(logic cmd, logic [BURST_W-1:0] burst);
		stim_t s;
		s.kind = STIM_WORD;
		s.cmd = cmd;
		s.burst = burst;
		s.quantum = '0;
		load_tick_q.push_back(s);
	endfunction

	function automatic void push_marker(stim_kind_t kind, logic [SLICE_W-1:0] quantum);
		stim_t s;
		s.kind = kind;
		s.cmd = CMD_TICK;
		s.burst = '0;
		s.quantum = quantum;
		load_tick_q.push_back(s);
	endfunction

	// Mostly short bursts so tasks retire; a rare full-range value.
	function automatic logic [BURST_W-1:0] pick_burst();
		int unsigned r;
		r = $urandom_range(999);
		if (r < 5) return BURST_W'($urandom());
		if (r < 45) return '0;
		if (r < 200) return BURST_W'($urandom_range(200, 13));
		return BURST_W'($urandom_range(12, 1));
	endfunction

	// Driver: present words at the falling edge, honor quantum writes and drains.
	int unsigned settle_cnt = 0;

	always @(negedge clk) begin : driver
		stim_t nxt;
		logic  valid_d;
		logic  we_d;
		valid_d = s_tvalid;
		we_d = 1'b0;
		// hold a word until it has been taken
		if (arst_n && !(s_tvalid && words_sent != words_in)) begin
			valid_d = 1'b0;
			if (load_tick_q.size() != 0) begin
				nxt = load_tick_q[0];
				case (nxt.kind)
					STIM_WORD: begin
						if ((words_sent >= CALM_LO && words_sent < CALM_HI) ||
						    $urandom_range(99) >= 19) begin
							void'(load_tick_q.pop_front());
							valid_d = 1'b1;
							s_tdata <= nxt.burst;
							s_tuser <= nxt.cmd;
							words_sent++;
						end
					end
					STIM_DRAIN: begin
						if (slot_reports_q.size() == 0) void'(load_tick_q.pop_front());
					end
					STIM_QUANTUM: begin
						// write only once the scheduler has gone quiet
						if (slot_reports_q.size() == 0) begin
							if (settle_cnt >= SETTLE) begin
								settle_cnt = 0;
								void'(load_tick_q.pop_front());
								we_d = 1'b1;
								quantum_wdata <= nxt.quantum;
							end else begin
								settle_cnt++;
							end
						end
					end
					default: void'(load_tick_q.pop_front());
				endcase
			end
		end
		s_tvalid <= valid_d;
		quantum_we <= we_d;
	end

	// Receiver: random backpressure, one long hold-off to fill the block.
	int unsigned holdoff_left = 0;
	bit          holdoff_done = 1'b0;

	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left--;
			m_tready <= 1'b0;
		end else if (!holdoff_done && words_in >= HOLDOFF_AT) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (reports_out >= CALM_LO && reports_out < CALM_HI) ||
			            ($urandom_range(99) >= 19);
		end
	end

	// Monitor: check the oldest report first, then predict the new word.
	always @(posedge clk) begin : monitor
		sched_report_t got;
		sched_report_t want;
		logic [M_PAD_W-1:0] pad;
		if (arst_n) begin
			if (quantum_we) quantum_reg = quantum_wdata;
			if (m_tvalid && m_tready) begin
				got.slot      = m_tdata[SLOT_O_W-1:0];
				got.remaining = m_tdata[SLOT_O_W +: BURST_W];
				got.elapsed   = m_tdata[SLOT_O_W + BURST_W +: ELAPSED_W];
				got.finished  = m_tuser[0];
				got.idle      = m_tuser[1];
				got.rejected  = m_tuser[2];
				pad = m_tdata[M_TDATA_W-1 -: M_PAD_W];
				reports_out++;
				if (slot_reports_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected report slot %0d rem %0d fin %0b idle %0b rej %0b elapsed %0d",
					         $time, got.slot, got.remaining, got.finished, got.idle,
					         got.rejected, got.elapsed);
				end else begin
					want = slot_reports_q.pop_front();
					if (got != want || pad != '0) begin
						mismatches++;
						$display("%0t: report mismatch expected slot %0d rem %0d fin %0b idle %0b rej %0b elapsed %0d pad 0",
						         $time, want.slot, want.remaining, want.finished, want.idle,
						         want.rejected, want.elapsed);
						$display("%0t:                 actual slot %0d rem %0d fin %0b idle %0b rej %0b elapsed %0d pad %0h",
						         $time, got.slot, got.remaining, got.finished, got.idle,
						         got.rejected, got.elapsed, pad);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				slot_reports_q.push_back(schedule_word(s_tuser[0], s_tdata[BURST_W-1:0]));
				words_in++;
			end
		end
	end

	// Watchdog: abort when nothing moves for too long.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || quantum_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("** round_robin_time_slice_scheduler: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [SLICE_W-1:0] phase_q [6];
		int                 left, seg_len, load_pct;
		logic               cmd;

		// Directed part, quantum at its reset value of 2.
		push_word(CMD_TICK, 16'hFFFF);        // tick on empty ring
		push_word(CMD_LOAD, 16'h0000);        // zero burst on empty ring
		push_word(CMD_LOAD, 16'hFFFF);        // slot 0, longest burst
		push_word(CMD_LOAD, 16'h0001);        // slot 1, shortest burst
		push_word(CMD_TICK, 16'h0000);
		push_word(CMD_TICK, 16'hFFFF);        // slice expires, pass to slot 1
		push_word(CMD_TICK, 16'h5555);        // slot 1 finishes and unlinks
		push_word(CMD_LOAD, 16'h0000);        // zero burst, ring not empty
		for (int i = 0; i < TASKS - 1; i++)
			push_word(CMD_LOAD, BURST_W'((i % 3) + 1));  // fill the ring
		push_word(CMD_LOAD, 16'hAAAA);        // ring full
		push_word(CMD_TICK, 16'h0000);

		// Random phases, each behind a drain and a quantum write.
		phase_q[0] = 8'd1;
		phase_q[1] = 8'd255;
		phase_q[2] = 8'd0;
		phase_q[3] = 8'd3;
		phase_q[4] = SLICE_W'($urandom_range(255, 1));
		phase_q[5] = QUANTUM_RESET;
		foreach (phase_q[p]) begin
			push_marker(STIM_DRAIN, '0);
			push_marker(STIM_QUANTUM, phase_q[p]);
			left = PHASE_WORDS;
			while (left > 0) begin
				// pick load-heavy, tick-heavy or mixed stretches at random
				case ($urandom_range(2))
					0: load_pct = 85;
					1: load_pct = 10;
					default: load_pct = 45;
				endcase
				seg_len = $urandom_range(40, 5);
				for (int k = 0; k < seg_len && left > 0; k++) begin
					cmd = ($urandom_range(99) < load_pct) ? CMD_LOAD : CMD_TICK;
					push_word(cmd, (cmd == CMD_LOAD) ? pick_burst() : BURST_W'($urandom()));
					left--;
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every word to go in and every report to come out.
		while (load_tick_q.size() != 0 || words_sent != words_in || slot_reports_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("** round_robin_time_slice_scheduler: PASSED **");
		else
			$display("** round_robin_time_slice_scheduler: FAILED **");
		$finish;
	end

endmodule
